@@ src/char_lcd_nibble_interface_defines.svh @@
// Assertion macros for the character LCD nibble interface.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define CLNI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clni assertion failed");

// Consequent in the cycle after the antecedent.
`define CLNI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clni assertion failed");

`endif

@@ src/clni_pkg.sv @@
// Shared types and constants for the character LCD nibble interface.
// No dependencies.
`timescale 1ns / 1ps

package clni_pkg;

	typedef enum logic [2:0] {
		REQ_INIT    = 3'd0,
		REQ_CLEAR   = 3'd1,
		REQ_HOME    = 3'd2,
		REQ_DISPLAY = 3'd3,
		REQ_CURSOR  = 3'd4,
		REQ_BLINK   = 3'd5,
		REQ_SETCUR  = 3'd6,
		REQ_CHAR    = 3'd7
	} req_type_t;

	typedef struct packed {
		req_type_t  req_type;
		logic       on_off;
		logic [5:0] column;
		logic [1:0] line_number;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] wait_before_us;
		logic [11:0] wait_after_us;
		logic        last;
	} rsp_t;

	// One classified command waiting in the queue.
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
		logic       long_wait;
		logic       two_line;
	} cmd_t;

	localparam logic [7:0] CMD_FUNC_2L    = 8'b0010_1000;
	localparam logic [7:0] CMD_FUNC_1L    = 8'b0010_0000;
	localparam logic [7:0] CMD_DISP_INIT  = 8'b0000_1100;
	localparam logic [7:0] CMD_CLEAR      = 8'b0000_0001;
	localparam logic [7:0] CMD_HOME       = 8'b0000_0010;
	localparam logic [7:0] CMD_ENTRY      = 8'b0000_0110;
	localparam logic [7:0] CMD_DISP_BASE  = 8'b0000_1000;
	localparam logic [7:0] CMD_ROW0_BASE  = 8'b1000_0000;
	localparam logic [7:0] CMD_ROW1_BASE  = 8'b1100_0000;
	localparam logic [3:0] NIB_WAKE       = 4'b0011;
	localparam logic [3:0] NIB_4BIT       = 4'b0010;
	localparam logic [2:0] FLAGS_RESET    = 3'b100;

	localparam logic [11:0] WAIT_STD      = 12'd50;
	localparam logic [11:0] WAIT_LONG     = 12'd2050;
	localparam logic [15:0] WAIT_PWR_UP   = 16'd40000;
	localparam logic [15:0] WAIT_WAKE2    = 16'd5000;
	localparam logic [15:0] WAIT_WAKE3    = 16'd100;

	localparam logic [5:0] COL_MIN        = 6'd1;
	localparam logic [5:0] COL_MAX        = 6'd40;

endpackage

@@ src/clni_front.sv @@
// Front end: accepts requests, keeps display flags and line mode, and
// turns each request into one queued command. Depends on clni_pkg.
`timescale 1ns / 1ps

module clni_front import clni_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	input  logic queue_full,
	output logic push,
	output cmd_t push_cmd
);

	logic       two_line_q;
	logic [2:0] flags_q;
	logic [2:0] flags_next;
	logic [5:0] col_clamped;
	logic [7:0] row_base;

	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full;

	always_comb begin
		if (req.column < COL_MIN) begin
			col_clamped = COL_MIN;
		end else if (req.column > COL_MAX) begin
			col_clamped = COL_MAX;
		end else begin
			col_clamped = req.column;
		end
		// Any line number other than one picks the second row.
		row_base = (req.line_number == 2'd1) ? CMD_ROW0_BASE : CMD_ROW1_BASE;
	end

	always_comb begin
		flags_next         = flags_q;
		push_cmd.is_init   = 1'b0;
		push_cmd.rs        = 1'b0;
		push_cmd.data      = 8'd0;
		push_cmd.long_wait = 1'b0;
		push_cmd.two_line  = two_line_q;
		unique case (req.req_type)
			REQ_INIT: begin
				push_cmd.is_init = 1'b1;
				flags_next       = FLAGS_RESET;
			end
			REQ_CLEAR: begin
				push_cmd.data      = CMD_CLEAR;
				push_cmd.long_wait = 1'b1;
			end
			REQ_HOME: begin
				push_cmd.data      = CMD_HOME;
				push_cmd.long_wait = 1'b1;
			end
			REQ_DISPLAY: begin
				flags_next[2] = req.on_off;
				push_cmd.data = CMD_DISP_BASE | {5'd0, flags_next};
			end
			REQ_CURSOR: begin
				flags_next[1] = req.on_off;
				push_cmd.data = CMD_DISP_BASE | {5'd0, flags_next};
			end
			REQ_BLINK: begin
				flags_next[0] = req.on_off;
				push_cmd.data = CMD_DISP_BASE | {5'd0, flags_next};
			end
			REQ_SETCUR: begin
				push_cmd.data = row_base | {2'd0, col_clamped - COL_MIN};
			end
			REQ_CHAR: begin
				push_cmd.rs   = 1'b1;
				push_cmd.data = req.char_code;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_line_q <= 1'b1;
			flags_q    <= FLAGS_RESET;
		end else begin
			if (cfg_we) begin
				two_line_q <= cfg_wdata;
			end
			if (push) begin
				flags_q <= flags_next;
			end
		end
	end

endmodule

@@ src/clni_queue.sv @@
// Short command queue between the front end and the nibble sequencer.
// Depends on clni_pkg for the command type.
`timescale 1ns / 1ps

module clni_queue import clni_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic nonempty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_FULL);
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/clni_back.sv @@
// Back end: steps through the queued command one nibble per cycle
// unless stalled, and holds each word in the output register. Depends on clni_pkg.
`timescale 1ns / 1ps

module clni_back import clni_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [3:0] INIT_LAST_STEP  = 4'd11;
	localparam logic [3:0] INIT_CLEAR_LOW  = 4'd9;
	localparam logic [3:0] INIT_BYTE_START = 4'd4;

	logic [3:0] step_q;
	logic       out_valid_q;
	rsp_t       out_q;
	rsp_t       nib_next;
	logic [7:0] cur_byte;
	logic       advance;

	assign advance   = cmd_valid && (!out_valid_q || !rsp_stall);
	assign pop       = advance && nib_next.last;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		if (cmd.is_init) begin
			// Init bytes follow the three wake-up nibbles and the 4-bit nibble, two steps per byte.
			unique case (step_q[3:1])
				3'd2:    cur_byte = cmd.two_line ? CMD_FUNC_2L : CMD_FUNC_1L;
				3'd3:    cur_byte = CMD_DISP_INIT;
				3'd4:    cur_byte = CMD_CLEAR;
				default: cur_byte = CMD_ENTRY;
			endcase
		end else begin
			cur_byte = cmd.data;
		end
	end

	always_comb begin
		nib_next.reg_select     = cmd.rs;
		nib_next.nibble         = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
		nib_next.wait_before_us = 16'd0;
		nib_next.wait_after_us  = WAIT_STD;
		nib_next.last           = step_q[0];
		if (cmd.is_init) begin
			nib_next.last = (step_q == INIT_LAST_STEP);
			if (step_q < INIT_BYTE_START) begin
				nib_next.nibble = (step_q == 4'd3) ? NIB_4BIT : NIB_WAKE;
				unique case (step_q[1:0])
					2'd0:    nib_next.wait_before_us = WAIT_PWR_UP;
					2'd1:    nib_next.wait_before_us = WAIT_WAKE2;
					2'd2:    nib_next.wait_before_us = WAIT_WAKE3;
					default: nib_next.wait_before_us = 16'd0;
				endcase
			end
			if (step_q == INIT_CLEAR_LOW) begin
				nib_next.wait_after_us = WAIT_LONG;
			end
		end else if (step_q[0] && cmd.long_wait) begin
			nib_next.wait_after_us = WAIT_LONG;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= nib_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= nib_next.last ? 4'd0 : step_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/char_lcd_nibble_interface.sv @@
// Flow: a request is registered in the queue, then its nibbles in the output register.
// Throughput: one nibble word per cycle while a command waits and rsp_stall is low.
// The sequencer's step counter sets the rate; the queue lets requests arrive meanwhile.
// Reset: queue and output empty, display on with cursor and blink off, two-line mode.
// Top level of the character LCD nibble interface.
// Instantiates clni_front, clni_queue and clni_back; uses clni_pkg and the defines header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_interface_defines.svh"

module char_lcd_nibble_interface import clni_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic push;
	logic pop;
	logic queue_full;
	logic queue_nonempty;
	cmd_t push_cmd;
	cmd_t head_cmd;

	clni_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	clni_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.head     (head_cmd),
		.nonempty (queue_nonempty)
	);

	clni_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_nonempty),
		.cmd       (head_cmd),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// An accepted request always leaves something queued for the sequencer.
	`CLNI_ASSERT_NEXT(a_push_fills_queue, req_valid && !req_stall, queue_nonempty)
	// The nibbles of one command come without gaps.
	`CLNI_ASSERT_NEXT(a_no_gap_in_command, rsp_valid && !rsp.last, rsp_valid)
	// Only the wake-up nibbles of init carry a wait before the strobe.
	`CLNI_ASSERT_SAME(a_wait_before_cmd_only, rsp_valid && rsp.wait_before_us != 16'd0,
		!rsp.reg_select && !rsp.last)

endmodule
